// ===== rtl/core/c2nec_pkg.sv =====
package c2nec_pkg;

  localparam int unsigned CMD_DEPTH_DEF = 4;
  localparam int unsigned RES_DEPTH_DEF = 4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_TICKS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE_UNITS = 2'd2;

  localparam logic [7:0]  DEVICE_ADDRESS_RST  = 8'hAC;
  localparam logic [15:0] UNIT_TICKS_RST      = 16'd1;
  localparam logic [3:0]  ONE_SPACE_UNITS_RST = 4'd3;

  localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
  localparam logic [7:0] CHAR_P_LOWER  = 8'h70;
  localparam logic [7:0] CHAR_P_UPPER  = 8'h50;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;

  localparam logic [4:0] CMD_POWER    = 5'h1C;
  localparam logic [4:0] CMD_VOL_UP   = 5'h10;
  localparam logic [4:0] CMD_VOL_DOWN = 5'h11;

  localparam logic [4:0] LEADER_UNITS = 5'd16;
  localparam logic [4:0] GAP_UNITS    = 5'd8;

  typedef struct packed {
    logic       is_char;
    logic       mapped;
    logic [4:0] cmd;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_started;
    logic dropped;
  } res_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/c2nec_fifo.sv =====
module c2nec_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/c2nec_front.sv =====
module c2nec_front (
  input  logic              in_push,
  input  logic              in_action,
  input  logic [7:0]        in_character,
  output logic              q_push,
  output c2nec_pkg::cmd_t   q_entry
);

  assign q_push = in_push;

  always_comb begin
    q_entry.is_char = in_action;
    q_entry.mapped  = 1'b0;
    q_entry.cmd     = '0;
    if (in_action) begin
      case (in_character) inside
        [c2nec_pkg::CHAR_DIGIT_LO:c2nec_pkg::CHAR_DIGIT_HI]: begin
          q_entry.mapped = 1'b1;
          q_entry.cmd    = 5'(in_character - c2nec_pkg::CHAR_DIGIT_LO);
        end
        c2nec_pkg::CHAR_P_LOWER, c2nec_pkg::CHAR_P_UPPER: begin
          q_entry.mapped = 1'b1;
          q_entry.cmd    = c2nec_pkg::CMD_POWER;
        end
        c2nec_pkg::CHAR_PLUS: begin
          q_entry.mapped = 1'b1;
          q_entry.cmd    = c2nec_pkg::CMD_VOL_UP;
        end
        c2nec_pkg::CHAR_MINUS: begin
          q_entry.mapped = 1'b1;
          q_entry.cmd    = c2nec_pkg::CMD_VOL_DOWN;
        end
        default: begin
          q_entry.mapped = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/c2nec_back.sv =====
module c2nec_back (
  input  logic               clk,
  input  logic               rst_n,
  input  c2nec_pkg::cfg_wr_t cfg_wr,
  input  logic               cmd_empty,
  input  c2nec_pkg::cmd_t    cmd_entry,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output c2nec_pkg::res_t    res
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEADER = 6'b000010,
    PH_GAP    = 6'b000100,
    PH_MARK   = 6'b001000,
    PH_SPACE  = 6'b010000,
    PH_STOP   = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  bit_pos_r, bit_pos_nxt;
  logic [31:0] frame_bits_r, frame_bits_nxt;
  logic [4:0]  units_left_r, units_left_nxt;
  logic [15:0] presc_r, presc_nxt;
  logic        line_r, line_nxt;

  logic [7:0]  dev_addr_r;
  logic [15:0] unit_ticks_r;
  logic [3:0]  one_space_r;

  logic        busy;
  logic [15:0] unit_len;
  logic [16:0] presc_inc;
  logic [4:0]  units_dec;
  logic [4:0]  space_one;
  logic [5:0]  bit_pos_inc;
  logic [7:0]  cmd8;

  assign busy        = (phase_r != PH_IDLE);
  assign unit_len    = (unit_ticks_r == '0) ? 16'd1 : unit_ticks_r;
  assign presc_inc   = {1'b0, presc_r} + 17'd1;
  assign units_dec   = (units_left_r != '0) ? units_left_r - 5'd1 : '0;
  assign space_one   = (one_space_r == '0) ? 5'd1 : {1'b0, one_space_r};
  assign bit_pos_inc = bit_pos_r + 6'd1;
  assign cmd8        = {3'b000, cmd_entry.cmd};

  always_comb begin
    phase_nxt      = phase_r;
    bit_pos_nxt    = bit_pos_r;
    frame_bits_nxt = frame_bits_r;
    units_left_nxt = units_left_r;
    presc_nxt      = presc_r;
    line_nxt       = line_r;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    if (!cmd_empty && !res_full) begin
      cmd_pop  = 1'b1;
      res_push = 1'b1;
      if (!cmd_entry.is_char) begin
        if (!busy) begin
          phase_nxt = PH_IDLE;
          line_nxt  = 1'b1;
          presc_nxt = '0;
        end else if (presc_inc < {1'b0, unit_len}) begin
          presc_nxt = presc_inc[15:0];
        end else begin
          presc_nxt      = '0;
          units_left_nxt = units_dec;
          if (units_dec == '0) begin
            case (phase_r)
              PH_LEADER: begin
                phase_nxt      = PH_GAP;
                line_nxt       = 1'b1;
                units_left_nxt = c2nec_pkg::GAP_UNITS;
              end
              PH_GAP: begin
                phase_nxt      = PH_MARK;
                line_nxt       = 1'b0;
                units_left_nxt = 5'd1;
              end
              PH_MARK: begin
                phase_nxt      = PH_SPACE;
                line_nxt       = 1'b1;
                units_left_nxt = frame_bits_r[bit_pos_r[4:0]] ? space_one : 5'd1;
              end
              PH_SPACE: begin
                bit_pos_nxt    = bit_pos_inc;
                phase_nxt      = bit_pos_inc[5] ? PH_STOP : PH_MARK;
                line_nxt       = 1'b0;
                units_left_nxt = 5'd1;
              end
              default: begin
                phase_nxt      = PH_IDLE;
                line_nxt       = 1'b1;
                units_left_nxt = '0;
              end
            endcase
          end
        end
      end else if (cmd_entry.mapped) begin
        if (busy) begin
          res.dropped = 1'b1;
        end else begin
          frame_bits_nxt    = {~cmd8, cmd8, ~dev_addr_r, dev_addr_r};
          bit_pos_nxt       = '0;
          presc_nxt         = '0;
          phase_nxt         = PH_LEADER;
          units_left_nxt    = c2nec_pkg::LEADER_UNITS;
          line_nxt          = 1'b0;
          res.frame_started = 1'b1;
        end
      end
      res.line_level = line_nxt;
      res.busy_res   = (phase_nxt != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_pos_r    <= '0;
      frame_bits_r <= '0;
      units_left_r <= '0;
      presc_r      <= '0;
      line_r       <= 1'b1;
      dev_addr_r   <= c2nec_pkg::DEVICE_ADDRESS_RST;
      unit_ticks_r <= c2nec_pkg::UNIT_TICKS_RST;
      one_space_r  <= c2nec_pkg::ONE_SPACE_UNITS_RST;
    end else begin
      phase_r      <= phase_nxt;
      bit_pos_r    <= bit_pos_nxt;
      frame_bits_r <= frame_bits_nxt;
      units_left_r <= units_left_nxt;
      presc_r      <= presc_nxt;
      line_r       <= line_nxt;
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          c2nec_pkg::REG_DEVICE_ADDRESS:  dev_addr_r   <= cfg_wr.data[7:0];
          c2nec_pkg::REG_UNIT_TICKS:      unit_ticks_r <= cfg_wr.data;
          c2nec_pkg::REG_ONE_SPACE_UNITS: one_space_r  <= cfg_wr.data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/char_to_nec_ir_transmitter.sv =====
// NEC infrared transmitter fed by a stream of items: each item is one base
// tick (action 0) or one received character (action 1). Digits, p/P, + and -
// start a frame with the configured address when the line is idle and are
// flagged as dropped while a frame is going out; other characters are ignored.
// Every item returns exactly one result with the line level after it. The
// block takes one item per clock while the result queue has room; an item is
// registered in the command queue, and the frame sequencer works on the head
// of that queue and writes the result into the result queue in the same
// clock. The sequencer stalls only while the result queue is full. Both queues
// hold CMD_DEPTH and RES_DEPTH entries, and configuration writes are always
// ready.
module char_to_nec_ir_transmitter #(
  parameter int unsigned CMD_DEPTH = c2nec_pkg::CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = c2nec_pkg::RES_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_action,
  input  logic [7:0]                        in_character,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_line_level,
  output logic                              out_busy_res,
  output logic                              out_frame_started,
  output logic                              out_dropped,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c2nec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [c2nec_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CMD_W = $bits(c2nec_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(c2nec_pkg::res_t);

  logic               q_push;
  c2nec_pkg::cmd_t    q_wentry;
  logic [CMD_W-1:0]   q_rdata;
  c2nec_pkg::cmd_t    q_rentry;
  logic               q_empty;
  logic               q_pop;
  logic               res_full;
  logic               res_push;
  c2nec_pkg::res_t    res_w;
  logic [RES_W-1:0]   res_rdata;
  c2nec_pkg::res_t    res_head;
  c2nec_pkg::cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  c2nec_front u_front (
    .in_push      (in_push),
    .in_action    (in_action),
    .in_character (in_character),
    .q_push       (q_push),
    .q_entry      (q_wentry)
  );

  c2nec_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wentry),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_rentry = c2nec_pkg::cmd_t'(q_rdata);

  c2nec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cmd_empty (q_empty),
    .cmd_entry (q_rentry),
    .cmd_pop   (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_w)
  );

  c2nec_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_w),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_head          = c2nec_pkg::res_t'(res_rdata);
  assign out_line_level    = res_head.line_level;
  assign out_busy_res      = res_head.busy_res;
  assign out_frame_started = res_head.frame_started;
  assign out_dropped       = res_head.dropped;

  a_start_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !(res_w.frame_started && res_w.dropped))
    else $error("frame start and drop flagged on one item");

  a_start_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_w.frame_started) |-> (res_w.busy_res && !res_w.line_level))
    else $error("started frame not busy with line low");

  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_w.dropped) |-> res_w.busy_res)
    else $error("character dropped while idle");

  a_pop_pairs_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop == res_push)
    else $error("command and result queues out of step");

endmodule
